// ===== rtl/tjlik_pkg.sv =====
// Shared constants and helpers for the three-joint leg inverse kinematics core.
// Holds fixed-point formats, the CORDIC arctangent table and output rounding.
// No dependencies.
`default_nettype none

package tjlik_pkg;

  // Default number of CORDIC micro-rotations
  localparam int CordicStages = 14;

  // Angle width inside the CORDIC (Q16 radians, signed)
  localparam int AngW = 20;
  // Width of one link-length register
  localparam int CfgW = 14;
  // Width of the tibia cosine (Q16, range -1..+1)
  localparam int CosW = 18;
  // Width of the Q16 output values before rounding
  localparam int QW = 24;

  localparam logic signed [AngW-1:0] HalfPiQ16 = 20'sd102944;
  localparam logic [15:0] InvKQ16 = 16'd39797;
  localparam logic signed [CosW-1:0] OneQ16 = 18'sd65536;

  // Configuration register indexes
  localparam logic [1:0] RegCoxa  = 2'd0;
  localparam logic [1:0] RegFemur = 2'd1;
  localparam logic [1:0] RegTibia = 2'd2;

  // round(atan(2^-i) * 2^16), zero from i = 17 on
  function automatic int atan_q16(int idx);
    int v;
    begin
      case (idx)
        0:       v = 51472;
        1:       v = 30386;
        2:       v = 16055;
        3:       v = 8150;
        4:       v = 4091;
        5:       v = 2047;
        6:       v = 1024;
        7:       v = 512;
        8:       v = 256;
        9:       v = 128;
        10:      v = 64;
        11:      v = 32;
        12:      v = 16;
        13:      v = 8;
        14:      v = 4;
        15:      v = 2;
        16:      v = 1;
        default: v = 0;
      endcase
      return v;
    end
  endfunction

  // Q16 to Q12: add half an LSB, floor, saturate to 16 bits
  function automatic logic signed [15:0] to_q12(logic signed [QW-1:0] v);
    logic signed [QW-1:0] t;
    begin
      t = (v + 24'sd8) >>> 4;
      if (t > 24'sd32767) begin
        return 16'sh7fff;
      end else if (t < -24'sd32768) begin
        return 16'sh8000;
      end
      return t[15:0];
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/tjlik_cordic.sv =====
// Pipelined vectoring CORDIC: angle and gain-corrected magnitude of (x, y).
// One register stage per micro-rotation plus pre-rotation and output stages.
// Depends on tjlik_pkg.
`default_nettype none

module tjlik_cordic #(
  parameter int W      = 28,
  parameter int STAGES = tjlik_pkg::CordicStages,
  parameter int TW     = 1
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  input  logic signed [W-1:0]                x_i,
  input  logic signed [W-1:0]                y_i,
  input  logic [TW-1:0]                      tag_i,
  output logic                               valid_o,
  output logic signed [tjlik_pkg::AngW-1:0]  ang_o,
  output logic signed [W-1:0]                mag_o,
  output logic [TW-1:0]                      tag_o
);
  import tjlik_pkg::*;

  logic [STAGES+1:0]       vld_q;
  logic signed [W-1:0]     x_q   [STAGES+1];
  logic signed [W-1:0]     y_q   [STAGES+1];
  logic signed [AngW-1:0]  z_q   [STAGES+1];
  logic                    zero_q[STAGES+1];
  logic [TW-1:0]           tag_q [STAGES+2];

  logic signed [W-1:0]     x0_d, y0_d;
  logic signed [AngW-1:0]  z0_d;
  logic signed [W+16:0]    prod_w, rnd_w;
  logic signed [AngW-1:0]  ang_q;
  logic signed [W-1:0]     mag_q;

  // Move the vector into the right half plane
  always_comb begin
    x0_d = x_i;
    y0_d = y_i;
    z0_d = '0;
    if (x_i < 0) begin
      if (y_i >= 0) begin
        x0_d = y_i;
        y0_d = -x_i;
        z0_d = HalfPiQ16;
      end else begin
        x0_d = -y_i;
        y0_d = x_i;
        z0_d = -HalfPiQ16;
      end
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[STAGES:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    x_q[0]    <= x0_d;
    y_q[0]    <= y0_d;
    z_q[0]    <= z0_d;
    zero_q[0] <= (x_i == '0) && (y_i == '0);
    tag_q[0]  <= tag_i;
  end

  // One micro-rotation per stage
  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    localparam logic signed [AngW-1:0] Atan = AngW'(atan_q16(s));
    always_ff @(posedge clk_i) begin
      if (y_q[s] >= 0) begin
        x_q[s+1] <= x_q[s] + (y_q[s] >>> s);
        y_q[s+1] <= y_q[s] - (x_q[s] >>> s);
        z_q[s+1] <= z_q[s] + Atan;
      end else begin
        x_q[s+1] <= x_q[s] - (y_q[s] >>> s);
        y_q[s+1] <= y_q[s] + (x_q[s] >>> s);
        z_q[s+1] <= z_q[s] - Atan;
      end
      zero_q[s+1] <= zero_q[s];
      tag_q[s+1]  <= tag_q[s];
    end
  end

  // Remove the CORDIC gain, round half up; force zero vector to angle zero
  assign prod_w = x_q[STAGES] * $signed({1'b0, InvKQ16});
  assign rnd_w  = prod_w + (W+17)'(32768);

  always_ff @(posedge clk_i) begin
    mag_q            <= rnd_w[W+15:16];
    ang_q            <= zero_q[STAGES] ? '0 : z_q[STAGES];
    tag_q[STAGES+1]  <= tag_q[STAGES];
  end

  assign valid_o = vld_q[STAGES+1];
  assign ang_o   = ang_q;
  assign mag_o   = mag_q;
  assign tag_o   = tag_q[STAGES+1];

endmodule

`default_nettype wire

// ===== rtl/tjlik_div.sv =====
// Pipelined restoring divider for the tibia cosine, one quotient bit a stage.
// Quotient is truncated toward zero and saturated to +/-1.0 in Q16.
// Depends on tjlik_pkg.
`default_nettype none

module tjlik_div #(
  parameter int NumW = 47,
  parameter int DenW = 29,
  parameter int TW   = 1
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  input  logic [NumW-1:0]                    num_i,
  input  logic                               neg_i,
  input  logic [DenW-1:0]                    den_i,
  input  logic [TW-1:0]                      tag_i,
  output logic                               valid_o,
  output logic signed [tjlik_pkg::CosW-1:0]  cos_o,
  output logic [TW-1:0]                      tag_o
);
  import tjlik_pkg::*;

  localparam int QBits = 17;

  logic [QBits+1:0]    vld_q;
  logic [NumW-1:0]     rem_q [QBits+1];
  logic [DenW-1:0]     den_q [QBits+1];
  logic [QBits-1:0]    quo_q [QBits+1];
  logic                sat_q [QBits+1];
  logic                neg_q [QBits+1];
  logic [TW-1:0]       tag_q [QBits+2];

  logic [CosW-1:0]     mag_w;
  logic signed [CosW-1:0] cos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[QBits:0], valid_i};
    end
  end

  // Flag quotients of 2^17 and above up front
  always_ff @(posedge clk_i) begin
    rem_q[0] <= num_i;
    den_q[0] <= den_i;
    quo_q[0] <= '0;
    sat_q[0] <= num_i >= (NumW'(den_i) << QBits);
    neg_q[0] <= neg_i;
    tag_q[0] <= tag_i;
  end

  // Subtract the shifted divisor where it fits
  for (genvar j = 0; j < QBits; j++) begin : g_bit
    localparam int K = QBits - 1 - j;
    logic [NumW-1:0] sub_w;
    assign sub_w = NumW'(den_q[j]) << K;
    always_ff @(posedge clk_i) begin
      if (rem_q[j] >= sub_w) begin
        rem_q[j+1] <= rem_q[j] - sub_w;
        quo_q[j+1] <= quo_q[j] | (QBits'(1) << K);
      end else begin
        rem_q[j+1] <= rem_q[j];
        quo_q[j+1] <= quo_q[j];
      end
      den_q[j+1] <= den_q[j];
      sat_q[j+1] <= sat_q[j];
      neg_q[j+1] <= neg_q[j];
      tag_q[j+1] <= tag_q[j];
    end
  end

  // Clamp to one, apply sign
  assign mag_w = (sat_q[QBits] || (quo_q[QBits] > QBits'(65536))) ?
                 CosW'(OneQ16) : CosW'(quo_q[QBits]);

  always_ff @(posedge clk_i) begin
    cos_q          <= neg_q[QBits] ? -$signed(mag_w) : $signed(mag_w);
    tag_q[QBits+1] <= tag_q[QBits];
  end

  assign valid_o = vld_q[QBits+1];
  assign cos_o   = cos_q;
  assign tag_o   = tag_q[QBits+1];

endmodule

`default_nettype wire

// ===== rtl/tjlik_sqrt.sv =====
// Pipelined floor integer square root of a 33-bit value, one result bit a stage.
// Gives the tibia sine in Q16 from 2^32 - c^2.
// Depends on tjlik_pkg.
`default_nettype none

module tjlik_sqrt #(
  parameter int TW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [32:0]   val_i,
  input  logic [TW-1:0] tag_i,
  output logic          valid_o,
  output logic [16:0]   root_o,
  output logic [TW-1:0] tag_o
);
  import tjlik_pkg::*;

  localparam int Steps = 17;
  localparam int RW    = 34;

  logic [Steps:0]    vld_q;
  logic [RW-1:0]     rem_q [Steps+1];
  logic [RW-1:0]     res_q [Steps+1];
  logic [TW-1:0]     tag_q [Steps+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Steps-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0] <= {1'b0, val_i};
    res_q[0] <= '0;
    tag_q[0] <= tag_i;
  end

  // Try the next power of four against the remainder
  for (genvar j = 0; j < Steps; j++) begin : g_step
    localparam logic [RW-1:0] Bit = RW'(1) << (2 * (Steps - 1 - j));
    logic [RW-1:0] trial_w;
    assign trial_w = res_q[j] + Bit;
    always_ff @(posedge clk_i) begin
      if (rem_q[j] >= trial_w) begin
        rem_q[j+1] <= rem_q[j] - trial_w;
        res_q[j+1] <= (res_q[j] >> 1) + Bit;
      end else begin
        rem_q[j+1] <= rem_q[j];
        res_q[j+1] <= res_q[j] >> 1;
      end
      tag_q[j+1] <= tag_q[j];
    end
  end

  assign valid_o = vld_q[Steps];
  assign root_o  = res_q[Steps][16:0];
  assign tag_o   = tag_q[Steps];

endmodule

`default_nettype wire

// ===== rtl/three_joint_leg_inverse_kinematics_core.sv =====
// Three-joint leg inverse kinematics core: foot target in, six joint angles out.
// Instantiates tjlik_cordic, tjlik_div and tjlik_sqrt; uses tjlik_pkg.
//
// The core is a fully pipelined datapath that takes one foot target on every
// clock cycle and never raises busy_o. Each result word appears on the result
// ports with done_o high for one cycle and is held there until the next word;
// the path runs through three CORDIC pipelines in series (hip angle,
// femur-to-foot vector, then the tibia and femur-offset vectors in parallel),
// the 17-bit cosine divider and the 17-bit square root. The receiver cannot
// stall: results must be taken as they come. The user must write link lengths
// through the cfg port while no target is in flight; the core does not enforce
// this.
`default_nettype none

module three_joint_leg_inverse_kinematics_core #(
  parameter int CORDIC_STAGES = tjlik_pkg::CordicStages
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_idx_i,
  input  logic [tjlik_pkg::CfgW-1:0] cfg_wdata_i,
  input  logic signed [15:0]         target_x_i,
  input  logic signed [15:0]         target_y_i,
  input  logic signed [15:0]         target_z_i,
  input  logic                       leg_side_i,
  output logic                       done_o,
  output logic signed [15:0]         hip_angle_o,
  output logic signed [15:0]         knee_upper_angle_o,
  output logic signed [15:0]         knee_lower_angle_o,
  output logic signed [15:0]         servo_hip_o,
  output logic signed [15:0]         servo_femur_o,
  output logic signed [15:0]         servo_tibia_o
);
  import tjlik_pkg::*;

  localparam int W1   = 28;   // hip and femur-to-foot CORDIC width
  localparam int W3   = 21;   // tibia angle CORDIC width
  localparam int W4   = 35;   // femur offset CORDIC width
  localparam int NumW = 47;
  localparam int DenW = 29;
  localparam int T1W  = 1 + W1;
  localparam int T2W  = 1 + AngW;
  localparam int T3W  = 1 + 2 * AngW;
  localparam int T4W  = T3W + CosW;

  // Link length registers and derived constants
  logic [CfgW-1:0]  coxa_q, femur_q, tibia_q;
  logic [CfgW:0]    dmax_q;
  logic [CfgW-1:0]  dmin_q;
  logic [DenW-1:0]  sumsq_q, den_q;
  logic             lz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coxa_q  <= 14'd2048;
      femur_q <= 14'd4096;
      tibia_q <= 14'd6144;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegCoxa:  coxa_q  <= cfg_wdata_i;
        RegFemur: femur_q <= cfg_wdata_i;
        RegTibia: tibia_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    dmax_q  <= {1'b0, femur_q} + {1'b0, tibia_q};
    dmin_q  <= (femur_q > tibia_q) ? femur_q - tibia_q : tibia_q - femur_q;
    sumsq_q <= DenW'(femur_q) * DenW'(femur_q) + DenW'(tibia_q) * DenW'(tibia_q);
    den_q   <= (DenW'(femur_q) * DenW'(tibia_q)) << 1;
    lz_q    <= (femur_q == '0) || (tibia_q == '0);
  end

  assign busy_o = 1'b0;

  // Hip angle and horizontal reach
  logic signed [W1-1:0]   x1_w, y1_w, h1_w;
  logic                   v1_vld;
  logic signed [AngW-1:0] th1_w;
  logic signed [W1-1:0]   r_w;
  logic [T1W-1:0]         t1_w;

  assign x1_w = {{4{target_x_i[15]}}, target_x_i, 8'h00};
  assign y1_w = {{4{target_y_i[15]}}, target_y_i, 8'h00};
  assign h1_w = {{4{target_z_i[15]}}, target_z_i, 8'h00};

  tjlik_cordic #(.W(W1), .STAGES(CORDIC_STAGES), .TW(T1W)) u_vec_hip (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i),
    .x_i     (x1_w),
    .y_i     (y1_w),
    .tag_i   ({leg_side_i, -h1_w}),
    .valid_o (v1_vld),
    .ang_o   (th1_w),
    .mag_o   (r_w),
    .tag_o   (t1_w)
  );

  // Subtract the coxa
  logic                   p_vld_q;
  logic signed [W1-1:0]   rr_q, nh_q;
  logic signed [AngW-1:0] p_th1_q;
  logic                   p_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else begin
      p_vld_q <= v1_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    rr_q     <= r_w - $signed({6'b0, coxa_q, 8'h00});
    nh_q     <= t1_w[W1-1:0];
    p_side_q <= t1_w[W1];
    p_th1_q  <= th1_w;
  end

  // Femur-to-foot vector
  logic                   v2_vld;
  logic signed [AngW-1:0] alpha_w;
  logic signed [W1-1:0]   d_w;
  logic [T2W-1:0]         t2_w;

  tjlik_cordic #(.W(W1), .STAGES(CORDIC_STAGES), .TW(T2W)) u_vec_reach (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (p_vld_q),
    .x_i     (rr_q),
    .y_i     (nh_q),
    .tag_i   ({p_side_q, p_th1_q}),
    .valid_o (v2_vld),
    .ang_o   (alpha_w),
    .mag_o   (d_w),
    .tag_o   (t2_w)
  );

  // Saturate distance, square it, form the cosine numerator
  logic signed [W1-1:0] dmax_w, dmin_w;
  logic                 a_vld_q, b_vld_q, c_vld_q;
  logic [22:0]          dc_q;
  logic [45:0]          dsq_q;
  logic [T3W-1:0]       a_tag_q, b_tag_q, c_tag_q;
  logic signed [47:0]   num_w;
  logic [NumW-1:0]      nabs_q;
  logic                 nneg_q;

  assign dmax_w = $signed({5'b0, dmax_q, 8'h00});
  assign dmin_w = $signed({6'b0, dmin_q, 8'h00});
  assign num_w  = $signed({2'b0, dsq_q}) - $signed({3'b0, sumsq_q, 16'h0000});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else begin
      a_vld_q <= v2_vld;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (d_w > dmax_w) begin
      dc_q <= dmax_w[22:0];
    end else if (d_w < dmin_w) begin
      dc_q <= dmin_w[22:0];
    end else begin
      dc_q <= d_w[22:0];
    end
    a_tag_q <= {t2_w, alpha_w};
    dsq_q   <= dc_q * dc_q;
    b_tag_q <= a_tag_q;
    nneg_q  <= num_w[47];
    nabs_q  <= num_w[47] ? NumW'(-num_w) : NumW'(num_w);
    c_tag_q <= b_tag_q;
  end

  // Tibia cosine
  logic                   dv_vld;
  logic signed [CosW-1:0] cdiv_w;
  logic [T3W-1:0]         dv_tag_w;

  tjlik_div #(.NumW(NumW), .DenW(DenW), .TW(T3W)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (c_vld_q),
    .num_i   (nabs_q),
    .neg_i   (nneg_q),
    .den_i   (den_q),
    .tag_i   (c_tag_q),
    .valid_o (dv_vld),
    .cos_o   (cdiv_w),
    .tag_o   (dv_tag_w)
  );

  // Take one for a zero-length link, then form 1 - c^2
  logic                   e_vld_q, f_vld_q;
  logic signed [CosW-1:0] e_cos_q, f_cos_q;
  logic [T3W-1:0]         e_tag_q, f_tag_q;
  logic signed [2*CosW-1:0] csq_w;
  logic [32:0]            v_q;

  assign csq_w = e_cos_q * e_cos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q <= 1'b0;
      f_vld_q <= 1'b0;
    end else begin
      e_vld_q <= dv_vld;
      f_vld_q <= e_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    e_cos_q <= lz_q ? OneQ16 : cdiv_w;
    e_tag_q <= dv_tag_w;
    v_q     <= 33'h1_0000_0000 - csq_w[32:0];
    f_cos_q <= e_cos_q;
    f_tag_q <= e_tag_q;
  end

  // Tibia sine
  logic           sq_vld;
  logic [16:0]    sn_w;
  logic [T4W-1:0] sq_tag_w;

  tjlik_sqrt #(.TW(T4W)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (f_vld_q),
    .val_i   (v_q),
    .tag_i   ({f_tag_q, f_cos_q}),
    .valid_o (sq_vld),
    .root_o  (sn_w),
    .tag_o   (sq_tag_w)
  );

  // Build the tibia and femur-offset vectors
  logic                   g_vld_q;
  logic signed [CosW-1:0] g_cos_w;
  logic signed [W3-1:0]   x3_q, y3_q;
  logic signed [W4-1:0]   x4_q, y4_q;
  logic [T3W-1:0]         g_tag_q;

  assign g_cos_w = sq_tag_w[CosW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_vld_q <= 1'b0;
    end else begin
      g_vld_q <= sq_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    x3_q    <= W3'(g_cos_w);
    y3_q    <= $signed({4'b0, sn_w});
    x4_q    <= $signed({5'b0, femur_q, 16'h0000}) + $signed({1'b0, tibia_q}) * g_cos_w;
    y4_q    <= $signed({1'b0, tibia_q}) * $signed({1'b0, sn_w});
    g_tag_q <= sq_tag_w[T4W-1:CosW];
  end

  logic signed [AngW-1:0] th3_w, beta_w;
  logic                   v4_vld;
  logic [T3W-1:0]         t4_w;

  tjlik_cordic #(.W(W3), .STAGES(CORDIC_STAGES), .TW(1)) u_vec_tibia (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (g_vld_q),
    .x_i     (x3_q),
    .y_i     (y3_q),
    .tag_i   (g_tag_q[T3W-1]),
    .valid_o (),
    .ang_o   (th3_w),
    .mag_o   (),
    .tag_o   ()
  );

  tjlik_cordic #(.W(W4), .STAGES(CORDIC_STAGES), .TW(T3W)) u_vec_femur (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (g_vld_q),
    .x_i     (x4_q),
    .y_i     (y4_q),
    .tag_i   (g_tag_q),
    .valid_o (v4_vld),
    .ang_o   (beta_w),
    .mag_o   (),
    .tag_o   (t4_w)
  );

  // Joint and servo angles in Q16
  logic                 side_w;
  logic signed [QW-1:0] th1_e, alpha_e, th2_w, th3_e, hp_e, sh_w, sf_w;
  logic                 h_vld_q;
  logic signed [QW-1:0] o_th1_q, o_th2_q, o_th3_q, o_sh_q, o_sf_q, o_st_q;

  assign side_w  = t4_w[T3W-1];
  assign th1_e   = QW'(signed'(t4_w[2*AngW-1:AngW]));
  assign alpha_e = QW'(signed'(t4_w[AngW-1:0]));
  assign th3_e   = QW'(th3_w);
  assign hp_e    = QW'(HalfPiQ16);
  assign th2_w   = alpha_e - QW'(beta_w);
  assign sh_w    = th1_e - hp_e;
  assign sf_w    = hp_e - th2_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_vld_q <= 1'b0;
      done_o  <= 1'b0;
    end else begin
      h_vld_q <= v4_vld;
      done_o  <= h_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    o_th1_q <= th1_e;
    o_th2_q <= th2_w;
    o_th3_q <= th3_e;
    o_sh_q  <= side_w ? -sh_w : sh_w;
    o_sf_q  <= side_w ? -sf_w : sf_w;
    o_st_q  <= side_w ? th3_e : -th3_e;
  end

  // Round to Q12 and hold until the next word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hip_angle_o        <= '0;
      knee_upper_angle_o <= '0;
      knee_lower_angle_o <= '0;
      servo_hip_o        <= '0;
      servo_femur_o      <= '0;
      servo_tibia_o      <= '0;
    end else if (h_vld_q) begin
      hip_angle_o        <= to_q12(o_th1_q);
      knee_upper_angle_o <= to_q12(o_th2_q);
      knee_lower_angle_o <= to_q12(o_th3_q);
      servo_hip_o        <= to_q12(o_sh_q);
      servo_femur_o      <= to_q12(o_sf_q);
      servo_tibia_o      <= to_q12(o_st_q);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tjlik_checker.sv =====
// Port-level checker for the three-joint leg inverse kinematics core.
// Bound to three_joint_leg_inverse_kinematics_core; uses tjlik_pkg.
`default_nettype none

module tjlik_checker #(
  parameter int CORDIC_STAGES = tjlik_pkg::CordicStages
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        done_o,
  input logic [15:0] hip_angle_o,
  input logic [15:0] knee_upper_angle_o,
  input logic [15:0] knee_lower_angle_o,
  input logic [15:0] servo_hip_o,
  input logic [15:0] servo_femur_o,
  input logic [15:0] servo_tibia_o
);
  import tjlik_pkg::*;

  localparam int Lat = 3 * CORDIC_STAGES + 52;

  // Every accepted target yields a word after the fixed latency
  a_start_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##Lat done_o)
    else $error("result word missing after start");

  // No word without a start at the matching earlier cycle
  a_done_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, Lat))
    else $error("result word without matching start");

  // Result ports change only with a new word
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !done_o |-> ($stable(hip_angle_o) && $stable(knee_upper_angle_o) &&
                 $stable(knee_lower_angle_o) && $stable(servo_hip_o) &&
                 $stable(servo_femur_o) && $stable(servo_tibia_o)))
    else $error("result ports changed without done");

endmodule

bind three_joint_leg_inverse_kinematics_core tjlik_checker #(
  .CORDIC_STAGES(CORDIC_STAGES)
) u_tjlik_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .start_i            (start_i),
  .busy_o             (busy_o),
  .done_o             (done_o),
  .hip_angle_o        (hip_angle_o),
  .knee_upper_angle_o (knee_upper_angle_o),
  .knee_lower_angle_o (knee_lower_angle_o),
  .servo_hip_o        (servo_hip_o),
  .servo_femur_o      (servo_femur_o),
  .servo_tibia_o      (servo_tibia_o)
);

`default_nettype wire

// ===== bench/tb_three_joint_leg_inverse_kinematics_core.sv =====
// Self-checking bench for the three-joint leg inverse kinematics core.
// Predicts joint and servo angles with a fixed-point CORDIC model of its own
// and compares every done word. Depends on tjlik_pkg and the core RTL.
`timescale 1ns / 1ps

typedef struct packed {
  logic signed [15:0] hip;
  logic signed [15:0] knee_up;
  logic signed [15:0] knee_lo;
  logic signed [15:0] s_hip;
  logic signed [15:0] s_femur;
  logic signed [15:0] s_tibia;
} leg_angles_t;

class leg_angle_scoreboard;
  longint coxa, femur, tibia;
  leg_angles_t pending[$];
  int mismatches;
  int words_checked;

  function new();
    coxa = 2048;
    femur = 4096;
    tibia = 6144;
    mismatches = 0;
    words_checked = 0;
  endfunction

  function void set_length(logic [1:0] idx, logic [13:0] val);
    if (idx == tjlik_pkg::RegCoxa) coxa = val;
    else if (idx == tjlik_pkg::RegFemur) femur = val;
    else if (idx == tjlik_pkg::RegTibia) tibia = val;
  endfunction

  // Vectoring CORDIC: Q16 angle and gain-corrected magnitude
  function void vector_angle(input longint vx, input longint vy,
                             output longint ang, output longint mag);
    longint arc[17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                        256, 128, 64, 32, 16, 8, 4, 2, 1};
    longint acc, nx, ny, swap;
    acc = 0;
    if (vx == 0 && vy == 0) begin
      ang = 0;
      mag = 0;
      return;
    end
    // pre-rotate into the right half plane
    if (vx < 0) begin
      swap = vx;
      if (vy >= 0) begin
        vx = vy; vy = -swap; acc = 102944;
      end else begin
        vx = -vy; vy = swap; acc = -102944;
      end
    end
    for (int i = 0; i < 14; i++) begin
      if (vy >= 0) begin
        nx = vx + (vy >>> i); ny = vy - (vx >>> i); acc += (i < 17) ? arc[i] : 0;
      end else begin
        nx = vx - (vy >>> i); ny = vy + (vx >>> i); acc -= (i < 17) ? arc[i] : 0;
      end
      vx = nx;
      vy = ny;
    end
    ang = acc;
    mag = (vx * 39797 + 32768) >>> 16;
  endfunction

  function longint floor_sqrt(longint v);
    longint res, b;
    res = 0;
    b = longint'(1) << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function logic signed [15:0] q12(longint v);
    longint t;
    t = (v + 8) >>> 4;
    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;
    return t[15:0];
  endfunction

  // Work out the expected angles of one accepted target and hold them
  function void note_target(logic signed [15:0] tx, logic signed [15:0] ty,
                            logic signed [15:0] tz, logic side);
    longint px, py, ph, sgn, th1, r, rr, alpha, d, dmax, dmin, c, num, den;
    longint sn, th2, th3, beta, dummy;
    leg_angles_t e;
    px = longint'(tx) * 256;
    py = longint'(ty) * 256;
    ph = longint'(tz) * 256;
    sgn = side ? -1 : 1;
    vector_angle(px, py, th1, r);
    rr = r - coxa * 256;
    vector_angle(rr, -ph, alpha, d);
    dmax = (femur + tibia) * 256;
    dmin = ((femur > tibia) ? femur - tibia : tibia - femur) * 256;
    if (d > dmax) d = dmax;
    if (d < dmin) d = dmin;
    if (femur == 0 || tibia == 0) begin
      c = 65536;
    end else begin
      num = d * d - (femur * femur + tibia * tibia) * 65536;
      den = 2 * femur * tibia * 65536;
      c = (num * 65536) / den;
      if (c > 65536) c = 65536;
      if (c < -65536) c = -65536;
    end
    sn = floor_sqrt((longint'(1) << 32) - c * c);
    vector_angle(c, sn, th3, dummy);
    vector_angle(femur * 65536 + tibia * c, tibia * sn, beta, dummy);
    th2 = alpha - beta;
    e.hip = q12(th1);
    e.knee_up = q12(th2);
    e.knee_lo = q12(th3);
    e.s_hip = q12(sgn * (th1 - 102944));
    e.s_femur = q12(sgn * (102944 - th2));
    e.s_tibia = q12(-sgn * th3);
    pending.push_back(e);
  endfunction

  // Compare one done word with the oldest expectation
  function void check_word(leg_angles_t got);
    leg_angles_t e;
    words_checked++;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected done word at %0t", $realtime);
      return;
    end
    e = pending.pop_front();
    if (got != e) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch at %0t: exp %0d %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d %0d",
                 $realtime, e.hip, e.knee_up, e.knee_lo, e.s_hip, e.s_femur, e.s_tibia,
                 got.hip, got.knee_up, got.knee_lo, got.s_hip, got.s_femur, got.s_tibia);
    end
  endfunction
endclass

module tb_three_joint_leg_inverse_kinematics_core;
  localparam logic [1:0] RegSpare = 2'd3;

  logic clk_i, rst_ni, start_i, busy_o, cfg_we_i, leg_side_i, done_o;
  logic [1:0] cfg_idx_i;
  logic [13:0] cfg_wdata_i;
  logic signed [15:0] target_x_i, target_y_i, target_z_i;
  logic signed [15:0] hip_angle_o, knee_upper_angle_o, knee_lower_angle_o;
  logic signed [15:0] servo_hip_o, servo_femur_o, servo_tibia_o;

  leg_angle_scoreboard sb;
  int targets_sent;
  int phases_run;
  bit no_gaps;

  three_joint_leg_inverse_kinematics_core DUT (.*);

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("timeout");
    $display("FAIL");
    $finish;
  end

  // Check every done word
  always @(posedge clk_i) begin
    leg_angles_t got;
    if (rst_ni && done_o) begin
      got.hip = hip_angle_o;
      got.knee_up = knee_upper_angle_o;
      got.knee_lo = knee_lower_angle_o;
      got.s_hip = servo_hip_o;
      got.s_femur = servo_femur_o;
      got.s_tibia = servo_tibia_o;
      sb.check_word(got);
    end
  end

  task automatic send_target(logic signed [15:0] tx, logic signed [15:0] ty,
                             logic signed [15:0] tz, logic side);
    int gap;
    gap = no_gaps ? 0 : int'($urandom_range(0, 8));
    repeat (gap) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    target_x_i <= tx;
    target_y_i <= ty;
    target_z_i <= tz;
    leg_side_i <= side;
    do @(posedge clk_i); while (busy_o);
    sb.note_target(tx, ty, tz, side);
    targets_sent++;
  endtask

  // Drain in-flight words, then write one length register
  task automatic write_length(logic [1:0] idx, logic [13:0] val);
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_length(idx, val);
  endtask

  task automatic set_leg(logic [13:0] cx, logic [13:0] fe, logic [13:0] ti);
    write_length(tjlik_pkg::RegCoxa, cx);
    write_length(tjlik_pkg::RegFemur, fe);
    write_length(tjlik_pkg::RegTibia, ti);
    phases_run++;
  endtask

  // Mostly targets around the leg's reach, some full range, some on the axes
  task automatic random_targets(int n);
    int sel, span;
    logic signed [15:0] tx, ty, tz;
    span = int'(sb.coxa + sb.femur + sb.tibia + 64);
    if (span > 32767) span = 32767;
    for (int k = 0; k < n; k++) begin
      sel = int'($urandom_range(0, 9));
      tx = 16'(int'($urandom_range(0, 2 * span)) - span);
      ty = 16'(int'($urandom_range(0, 2 * span)) - span);
      tz = 16'(int'($urandom_range(0, 2 * span)) - span);
      if (sel >= 6 && sel < 9) begin
        tx = 16'($urandom);
        ty = 16'($urandom);
        tz = 16'($urandom);
      end else if (sel == 9) begin
        if ($urandom_range(0, 1)) tx = 0;
        if ($urandom_range(0, 1)) ty = 0;
        if ($urandom_range(0, 1)) tz = 0;
      end
      send_target(tx, ty, tz, 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    sb = new();
    targets_sent = 0;
    phases_run = 0;
    no_gaps = 1'b0;
    rst_ni = 1'b0;
    start_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = tjlik_pkg::RegCoxa;
    cfg_wdata_i = '0;
    target_x_i = '0;
    target_y_i = '0;
    target_z_i = '0;
    leg_side_i = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset lengths, field extremes, each quadrant, both sides
    send_target(0, 0, 0, 0);
    send_target(16'sh7fff, 16'sh7fff, 16'sh7fff, 0);
    send_target(16'sh8000, 16'sh8000, 16'sh8000, 1);
    send_target(16'sh8000, 100, 0, 0);
    send_target(-100, -200, 300, 1);
    send_target(-5, 0, -5, 0);
    send_target(8000, 0, -6000, 0);
    send_target(8000, 0, -6000, 1);
    send_target(2048, 0, 0, 0);
    send_target(6000, 3000, -2000, 1);
    send_target(16'sh7fff, 16'sh8000, 0, 0);
    send_target(0, 16'sh7fff, 16'sh8000, 1);
    // unknown register index is dropped
    write_length(RegSpare, 14'h3fff);
    send_target(9000, 1000, -3000, 0);
    // zero and extreme lengths
    set_leg(0, 0, 6144);
    send_target(4000, 0, -4000, 0);
    set_leg(16383, 16383, 0);
    send_target(4000, 100, -4000, 1);
    set_leg(16383, 16383, 16383);
    send_target(16'sh7fff, 0, 0, 0);
    send_target(20000, -20000, 20000, 1);
    set_leg(0, 1, 1);
    send_target(0, 0, 0, 0);
    send_target(1, 0, 1, 1);
    send_target(3, 2, -1, 0);

    // random phases over several leg shapes, back-to-back in some
    set_leg(2048, 4096, 6144);
    random_targets(300);
    set_leg(0, 1, 16383);
    random_targets(200);
    set_leg(16383, 16383, 1);
    random_targets(200);
    no_gaps = 1'b1;
    set_leg(14'($urandom_range(0, 16383)), 14'($urandom_range(1, 16383)),
            14'($urandom_range(1, 16383)));
    random_targets(300);
    no_gaps = 1'b0;
    set_leg(14'($urandom_range(0, 4000)), 14'($urandom_range(1, 6000)),
            14'($urandom_range(1, 6000)));
    random_targets(300);
    for (int p = 0; p < 5; p++) begin
      no_gaps = (p == 2);
      set_leg(14'($urandom_range(0, 16383)), 14'($urandom_range(1, 16383)),
              14'($urandom_range(1, 16383)));
      random_targets(110);
    end
    no_gaps = 1'b0;
    start_i <= 1'b0;

    // drain, then let the pipeline settle
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);

    $display("%0d targets over %0d leg shapes, %0d result words checked, %0d mismatches",
             targets_sent, phases_run, sb.words_checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
